// ===== hdl/jmx_pkg.sv =====
// Shared types, marker codes and record layout for the JPEG marker and Exif scanner.
package jmx_pkg;

   localparam int MAX_SEGMENTS_DEF = 255;
   localparam int OFFSET_BITS_DEF  = 32;

   // Marker bytes that the scanner handles specially.
   localparam logic [7:0] MARK_FILL = 8'hFF;
   localparam logic [7:0] MARK_RST0 = 8'hD0;
   localparam logic [7:0] MARK_EOI  = 8'hD9;
   localparam logic [7:0] MARK_SOS  = 8'hDA;
   localparam logic [7:0] MARK_APP0 = 8'hE0;
   localparam logic [7:0] MARK_APP1 = 8'hE1;

   // Record kinds.
   localparam logic [1:0] KIND_SEGMENT = 2'd0;
   localparam logic [1:0] KIND_SOS     = 2'd1;
   localparam logic [1:0] KIND_EOI     = 2'd2;
   localparam logic [1:0] KIND_TRUNC   = 2'd3;

   localparam logic [2:0] SIG_LEN = 3'd6;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  marker_code;
      logic [7:0]  segment_index;
      logic [15:0] segment_length;
      logic [31:0] payload_offset;
      logic        is_exif;
      logic        bad_length;
      logic [7:0]  insert_position;
      logic        exif_found;
      logic [31:0] exif_offset;
      logic [15:0] exif_length;
      logic        last_in_run;
   } rec_type;

   // Records produced by one byte, handed from the scan stage to the result queue.
   typedef struct packed {
      logic [1:0] count;
      rec_type    first;
      rec_type    second;
   } push_type;

   // The six bytes "Exif", 0, 0 that open an Exif APP1 payload.
   function automatic logic [7:0] exif_sig_byte(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0:    val = 8'h45;
         3'd1:    val = 8'h78;
         3'd2:    val = 8'h69;
         3'd3:    val = 8'h66;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// ===== hdl/jmx_req_if.sv =====
// Request channel carrying one file byte per transfer.
interface jmx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_file;
   logic       end_of_file;

   modport source (output valid, data_byte, start_of_file, end_of_file, input ready);
   modport sink   (input valid, data_byte, start_of_file, end_of_file, output ready);
endinterface

// ===== hdl/jmx_rsp_if.sv =====
// Response channel carrying one segment or summary record per transfer.
interface jmx_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  marker_code;
   logic [7:0]  segment_index;
   logic [15:0] segment_length;
   logic [31:0] payload_offset;
   logic        is_exif;
   logic        bad_length;
   logic [7:0]  insert_position;
   logic        exif_found;
   logic [31:0] exif_offset;
   logic [15:0] exif_length;
   logic        last_in_run;

   modport source (output valid, kind, marker_code, segment_index, segment_length,
                   payload_offset, is_exif, bad_length, insert_position, exif_found,
                   exif_offset, exif_length, last_in_run, input ready);
   modport sink   (input valid, kind, marker_code, segment_index, segment_length,
                   payload_offset, is_exif, bad_length, insert_position, exif_found,
                   exif_offset, exif_length, last_in_run, output ready);
endinterface

// ===== hdl/jmx_scan.sv =====
// Input register and per-byte marker scan that builds segment and summary records.
module jmx_scan #(
   parameter int MAX_SEGMENTS = 255,
   parameter int OFFSET_BITS  = 32
) (
   input  logic              clock,
   input  logic              reset,
   jmx_req_if.sink           req_chan,
   input  logic              room,
   output jmx_pkg::push_type push
);
   import jmx_pkg::*;

   localparam int SEG_CAP = (MAX_SEGMENTS < 255) ? MAX_SEGMENTS : 255;
   localparam int OW      = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
   localparam logic [7:0] CAP8 = 8'(SEG_CAP);

   typedef enum logic [2:0] {
      PH_SEEK, PH_MARK, PH_LHI, PH_LLO, PH_BODY, PH_IDLE
   } phase_type;

   logic                   in_valid_ff;
   logic [7:0]             data_ff;
   logic                   sof_ff;
   logic                   eof_ff;

   phase_type              phase_ff, phase_in, phase_cur;
   logic [7:0]             marker_ff, marker_in;
   logic [15:0]            length_ff, length_in;
   logic [15:0]            left_ff, left_in;
   logic [2:0]             sig_count_ff, sig_count_in;
   logic                   sig_match_ff, sig_match_in;
   logic [7:0]             seg_count_ff, seg_count_in;
   logic [7:0]             app0_next_ff, app0_next_in;
   logic                   exif_seen_ff, exif_seen_in;
   logic [31:0]            exif_offset_ff, exif_offset_in;
   logic [15:0]            exif_length_ff, exif_length_in;
   logic [31:0]            seg_offset_ff, seg_offset_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;

   logic                   fire;
   logic [OFFSET_BITS-1:0] pos_next;
   logic [7:0]             seg_idx;
   logic [15:0]            len_full;
   logic                   active;
   logic                   emit;
   logic                   ended;
   logic                   trailer;
   logic [1:0]             end_kind;
   logic [15:0]            seg_len;
   logic [31:0]            seg_off;
   logic                   seg_exif;
   logic                   seg_bad;
   rec_type                seg_rec;
   rec_type                sum_rec;

   assign fire           = in_valid_ff && room;
   assign req_chan.ready = !in_valid_ff || fire;

   always_comb begin
      phase_in       = phase_ff;
      marker_in      = marker_ff;
      length_in      = length_ff;
      left_in        = left_ff;
      sig_count_in   = sig_count_ff;
      sig_match_in   = sig_match_ff;
      seg_count_in   = seg_count_ff;
      app0_next_in   = app0_next_ff;
      exif_seen_in   = exif_seen_ff;
      exif_offset_in = exif_offset_ff;
      exif_length_in = exif_length_ff;
      seg_offset_in  = seg_offset_ff;
      pos_in         = pos_ff;

      // A new file clears every piece of scan state before its first byte is looked at.
      if (sof_ff) begin
         phase_in       = PH_SEEK;
         marker_in      = '0;
         length_in      = '0;
         left_in        = '0;
         sig_count_in   = '0;
         sig_match_in   = 1'b0;
         seg_count_in   = '0;
         app0_next_in   = '0;
         exif_seen_in   = 1'b0;
         exif_offset_in = '0;
         exif_length_in = '0;
         seg_offset_in  = '0;
         pos_in         = '0;
      end

      phase_cur = phase_in;
      seg_idx   = seg_count_in;
      pos_next  = pos_in + OFFSET_BITS'(1);
      len_full  = {length_in[15:8], data_ff};
      active    = 1'b0;
      emit      = 1'b0;
      ended     = 1'b0;
      end_kind  = KIND_SOS;
      seg_len   = '0;
      seg_off   = 32'(pos_next[OW-1:0]);
      seg_exif  = 1'b0;
      seg_bad   = 1'b0;

      unique case (phase_cur)
         PH_SEEK: begin
            active = 1'b1;
            if (data_ff == MARK_FILL) begin
               phase_in = PH_MARK;
            end
         end
         PH_MARK: begin
            active = 1'b1;
            if (data_ff != MARK_FILL) begin
               marker_in = data_ff;
               if (data_ff == MARK_SOS || data_ff == MARK_EOI) begin
                  ended    = 1'b1;
                  end_kind = (data_ff == MARK_SOS) ? KIND_SOS : KIND_EOI;
                  phase_in = PH_IDLE;
               end else if (data_ff >= MARK_RST0 && data_ff < MARK_EOI) begin
                  emit     = 1'b1;
                  phase_in = PH_SEEK;
               end else begin
                  phase_in = PH_LHI;
               end
            end
         end
         PH_LHI: begin
            active    = 1'b1;
            length_in = {data_ff, 8'h00};
            phase_in  = PH_LLO;
         end
         PH_LLO: begin
            active       = 1'b1;
            length_in    = len_full;
            sig_count_in = '0;
            sig_match_in = 1'b1;
            if (len_full <= 16'd2) begin
               emit     = 1'b1;
               seg_len  = len_full;
               seg_bad  = (len_full < 16'd2);
               phase_in = PH_SEEK;
            end else begin
               left_in       = len_full - 16'd2;
               seg_offset_in = seg_off;
               phase_in      = PH_BODY;
            end
         end
         PH_BODY: begin
            active = 1'b1;
            if (sig_count_in < SIG_LEN) begin
               if (data_ff != exif_sig_byte(sig_count_in)) begin
                  sig_match_in = 1'b0;
               end
               sig_count_in = sig_count_in + 3'd1;
            end
            left_in = left_in - 16'd1;
            if (left_in == 16'd0) begin
               // Payload bytes arrive at consecutive offsets, so the start
               // offset saved at the length field is the payload offset.
               emit     = 1'b1;
               seg_len  = length_in;
               seg_off  = seg_offset_in;
               seg_exif = (marker_in == MARK_APP1) && (length_in >= 16'd8) &&
                          sig_match_in && (sig_count_in >= SIG_LEN);
               phase_in = PH_SEEK;
            end
         end
         default: begin
            // Scan has ended; bytes are dropped until the next start of file.
         end
      endcase

      if (emit) begin
         if (marker_in == MARK_APP0) begin
            app0_next_in = (seg_idx < CAP8) ? seg_idx + 8'd1 : CAP8;
         end
         if (seg_exif && !exif_seen_in) begin
            exif_seen_in   = 1'b1;
            exif_offset_in = seg_off;
            exif_length_in = seg_len;
         end
         if (seg_count_in < CAP8) begin
            seg_count_in = seg_count_in + 8'd1;
         end
      end

      if (active) begin
         pos_in = pos_next;
      end

      trailer = active && eof_ff && !ended;
      if (trailer) begin
         phase_in = PH_IDLE;
      end

      seg_rec.kind            = KIND_SEGMENT;
      seg_rec.marker_code     = marker_in;
      seg_rec.segment_index   = seg_idx;
      seg_rec.segment_length  = seg_len;
      seg_rec.payload_offset  = seg_off;
      seg_rec.is_exif         = seg_exif;
      seg_rec.bad_length      = seg_bad;
      seg_rec.insert_position = app0_next_in;
      seg_rec.exif_found      = exif_seen_in;
      seg_rec.exif_offset     = exif_offset_in;
      seg_rec.exif_length     = exif_length_in;
      seg_rec.last_in_run     = !trailer;

      sum_rec.kind            = ended ? end_kind : KIND_TRUNC;
      sum_rec.marker_code     = marker_in;
      sum_rec.segment_index   = seg_count_in;
      sum_rec.segment_length  = '0;
      sum_rec.payload_offset  = '0;
      sum_rec.is_exif         = 1'b0;
      sum_rec.bad_length      = 1'b0;
      sum_rec.insert_position = app0_next_in;
      sum_rec.exif_found      = exif_seen_in;
      sum_rec.exif_offset     = exif_offset_in;
      sum_rec.exif_length     = exif_length_in;
      sum_rec.last_in_run     = 1'b1;

      push.first  = emit ? seg_rec : sum_rec;
      push.second = sum_rec;
      if (!fire) begin
         push.count = 2'd0;
      end else if (emit) begin
         push.count = trailer ? 2'd2 : 2'd1;
      end else begin
         push.count = (ended || trailer) ? 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         phase_ff       <= PH_SEEK;
         marker_ff      <= '0;
         length_ff      <= '0;
         left_ff        <= '0;
         sig_count_ff   <= '0;
         sig_match_ff   <= 1'b0;
         seg_count_ff   <= '0;
         app0_next_ff   <= '0;
         exif_seen_ff   <= 1'b0;
         exif_offset_ff <= '0;
         exif_length_ff <= '0;
         seg_offset_ff  <= '0;
         pos_ff         <= '0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (fire) begin
            phase_ff       <= phase_in;
            marker_ff      <= marker_in;
            length_ff      <= length_in;
            left_ff        <= left_in;
            sig_count_ff   <= sig_count_in;
            sig_match_ff   <= sig_match_in;
            seg_count_ff   <= seg_count_in;
            app0_next_ff   <= app0_next_in;
            exif_seen_ff   <= exif_seen_in;
            exif_offset_ff <= exif_offset_in;
            exif_length_ff <= exif_length_in;
            seg_offset_ff  <= seg_offset_in;
            pos_ff         <= pos_in;
         end
      end
      if (req_chan.ready && req_chan.valid) begin
         data_ff <= req_chan.data_byte;
         sof_ff  <= req_chan.start_of_file;
         eof_ff  <= req_chan.end_of_file;
      end
   end

   // Two records from one byte are always a segment followed by an early-end summary.
   assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.first.kind == KIND_SEGMENT &&
                             push.second.kind == KIND_TRUNC &&
                             !push.first.last_in_run && push.second.last_in_run)
      else $error("jmx_scan: malformed record pair");

   // Any summary record puts the scan into its ended phase.
   assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 && (push.count == 2'd2 || push.first.kind != KIND_SEGMENT)
      |=> phase_ff == PH_IDLE)
      else $error("jmx_scan: scan continued after summary record");

   // Records are only produced for a byte that is actually consumed.
   assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> fire)
      else $error("jmx_scan: records pushed without a consumed byte");

endmodule

// ===== hdl/jmx_rsp_queue.sv =====
// Three-entry result queue that takes up to two records a cycle and drives the response channel.
module jmx_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  jmx_pkg::push_type push,
   output logic              room,
   jmx_rsp_if.source         rsp_chan
);
   import jmx_pkg::*;

   localparam int DEPTH = 3;

   rec_type    q_ff [DEPTH];
   rec_type    q_in [DEPTH];
   rec_type    shifted [DEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] base;
   logic       pop;

   assign pop  = (cnt_ff != 2'd0) && rsp_chan.ready;
   assign base = cnt_ff - {1'b0, pop};
   // Two free places must remain after this cycle's pop before a byte is scanned.
   assign room = (base <= 2'd1);

   always_comb begin
      shifted[0] = pop ? q_ff[1] : q_ff[0];
      shifted[1] = pop ? q_ff[2] : q_ff[1];
      shifted[2] = q_ff[2];
      for (int i = 0; i < DEPTH; i++) begin
         if (2'(i) < base) begin
            q_in[i] = shifted[i];
         end else if (2'(i) == base && push.count != 2'd0) begin
            q_in[i] = push.first;
         end else if (2'(i) == base + 2'd1 && push.count == 2'd2) begin
            q_in[i] = push.second;
         end else begin
            q_in[i] = q_ff[i];
         end
      end
      cnt_in = base + push.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      for (int i = 0; i < DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   assign rsp_chan.valid           = (cnt_ff != 2'd0);
   assign rsp_chan.kind            = q_ff[0].kind;
   assign rsp_chan.marker_code     = q_ff[0].marker_code;
   assign rsp_chan.segment_index   = q_ff[0].segment_index;
   assign rsp_chan.segment_length  = q_ff[0].segment_length;
   assign rsp_chan.payload_offset  = q_ff[0].payload_offset;
   assign rsp_chan.is_exif         = q_ff[0].is_exif;
   assign rsp_chan.bad_length      = q_ff[0].bad_length;
   assign rsp_chan.insert_position = q_ff[0].insert_position;
   assign rsp_chan.exif_found      = q_ff[0].exif_found;
   assign rsp_chan.exif_offset     = q_ff[0].exif_offset;
   assign rsp_chan.exif_length     = q_ff[0].exif_length;
   assign rsp_chan.last_in_run     = q_ff[0].last_in_run;

   // A push never arrives without space for all of its records.
   assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> {1'b0, base} + {1'b0, push.count} <= 3'(DEPTH))
      else $error("jmx_rsp_queue: result queue overflow");

   // A record that is offered and not taken stays at the head of the queue.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> cnt_ff != 2'd0 && $stable(q_ff[0]))
      else $error("jmx_rsp_queue: stalled head record changed");

endmodule

// ===== hdl/jpeg_marker_exif_scanner_core.sv =====
// Top level of the JPEG marker segment scanner with Exif detection.
//
//   Channel   Direction  Moves
//   req_chan  in         one file byte with start and end of file flags per request
//   rsp_chan  out        one segment record or summary record per request
//
// Each request is scanned combinationally once it lands in the input register, so a
// byte is taken every cycle while the response side keeps up; records then pass into the result queue register.
// A byte that closes a segment and also ends the file gives two records, which
// leave one after the other through the three-entry result queue.
// Reset is synchronous and clears all scan state at once; no clearing pass is needed.
// When the response side stalls, the queue fills and then the request side stalls.
module jpeg_marker_exif_scanner_core #(
   parameter int MAX_SEGMENTS = jmx_pkg::MAX_SEGMENTS_DEF,
   parameter int OFFSET_BITS  = jmx_pkg::OFFSET_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   jmx_req_if.sink   req_chan,
   jmx_rsp_if.source rsp_chan
);
   import jmx_pkg::*;

   push_type push;
   logic     room;

   jmx_scan #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .OFFSET_BITS  (OFFSET_BITS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .room     (room),
      .push     (push)
   );

   jmx_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule
